[rtl/stable_priority_queue_defines.svh]
// Assertion macros used by the checker file of the priority queue.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("priority queue check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("priority queue check failed");

`endif

[rtl/spq_pkg.sv]
package spq_pkg;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Request codes.
	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

endpackage

[rtl/spq_mem.sv]
module spq_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 36,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one read port; read data is registered and appears in the cycle after the address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/stable_priority_queue.sv]
// Stable bounded priority queue holding up to CAPACITY entries. A request is taken when start is
// high while busy is low; op selects an enqueue of payload at priority_req or a dequeue of the
// entry with the highest priority, and entries of equal priority leave in the order they came.
// Every request yields exactly one result, shown for a single cycle while done is high, and the
// receiver cannot stall it, so it must capture the result in that cycle. A request that ends at
// once (a dequeue from an empty queue, an enqueue into a full queue, or an enqueue into an empty
// queue) shows its result in the next cycle and the block is ready again in that same cycle, one
// request per cycle. A dequeue makes one memory read of the head entry and passes through S_DEQ. An
// enqueue into a non-empty queue walks from the tail toward the head, one memory write per cycle,
// moving each entry of strictly lower priority back by one slot, then writes the new entry in the
// freed slot. No clearing pass is needed after reset, since only data read from slots holding live
// entries is ever used.
module stable_priority_queue #(
	parameter int CAPACITY      = 16,
	parameter int PAYLOAD_BITS  = 32,
	parameter int PRIORITY_BITS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          op,
	input  logic [PAYLOAD_BITS-1:0]       payload,
	input  logic [PRIORITY_BITS-1:0]      priority_req,
	output logic                          done,
	output logic [PAYLOAD_BITS-1:0]       out_payload,
	output logic [PRIORITY_BITS-1:0]      out_priority,
	output spq_pkg::status_t              status,
	output logic                          is_empty,
	output logic [$clog2(CAPACITY+1)-1:0] occupancy
);

	import spq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = PRIORITY_BITS + PAYLOAD_BITS;
	localparam logic [AW:0]   CAP_A = (AW+1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	// The entries form a sorted ring in memory: logical slot 0 is at head_q and holds the
	// entry served next. A dequeue only advances the head, so nothing needs to move.
	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_PLACE,
		S_DEQ
	} state_t;

	state_t                   state_q;
	logic [AW-1:0]            head_q;
	logic [CW-1:0]            count_q;
	logic [AW-1:0]            walk_q;
	logic [PAYLOAD_BITS-1:0]  pay_q;
	logic [PRIORITY_BITS-1:0] pri_q;
	logic                     done_q;
	logic [PAYLOAD_BITS-1:0]  out_pay_q;
	logic [PRIORITY_BITS-1:0] out_pri_q;
	status_t                  status_q;
	logic                     empty_q;
	logic [CW-1:0]            occ_q;

	logic                     mem_we;
	logic [AW-1:0]            mem_waddr;
	logic [EW-1:0]            mem_wdata;
	logic [AW-1:0]            mem_raddr;
	logic [EW-1:0]            mem_rdata;
	logic [PRIORITY_BITS-1:0] rd_pri;
	logic [PAYLOAD_BITS-1:0]  rd_pay;
	logic                     rd_lower;
	logic                     take;
	logic [CW-1:0]            count_inc;
	logic [CW-1:0]            count_dec;

	// Maps a logical slot to its physical address in the ring.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW-1:0] idx);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, idx};
		if (sum >= CAP_A) begin
			sum = sum - CAP_A;
		end
		return sum[AW-1:0];
	endfunction

	spq_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (EW),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign take      = start && (state_q == S_IDLE);
	assign rd_pri    = mem_rdata[EW-1:PAYLOAD_BITS];
	assign rd_pay    = mem_rdata[PAYLOAD_BITS-1:0];
	assign rd_lower  = rd_pri < pri_q;
	assign count_inc = count_q + CW'(1);
	assign count_dec = count_q - CW'(1);

	// Memory accesses. During the walk the read runs one slot ahead of the comparison and
	// the write lands one slot behind it, so a read never meets a slot written in this pass.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					if (op == OP_DEQ) begin
						mem_raddr = head_q;
					end else if (count_q == '0) begin
						mem_we    = 1'b1;
						mem_waddr = head_q;
						mem_wdata = {priority_req, payload};
					end else begin
						mem_raddr = phys(head_q, count_dec[AW-1:0]);
					end
				end
			end
			S_WALK: begin
				mem_we    = 1'b1;
				mem_waddr = phys(head_q, walk_q + AW'(1));
				if (rd_lower) begin
					mem_wdata = mem_rdata;
					if (walk_q != '0) begin
						mem_raddr = phys(head_q, walk_q - AW'(1));
					end
				end else begin
					mem_wdata = {pri_q, pay_q};
				end
			end
			S_PLACE: begin
				// Every held entry had lower priority, so the new one becomes the head.
				mem_we    = 1'b1;
				mem_waddr = head_q;
				mem_wdata = {pri_q, pay_q};
			end
			S_DEQ: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			walk_q    <= '0;
			pay_q     <= '0;
			pri_q     <= '0;
			done_q    <= 1'b0;
			out_pay_q <= '0;
			out_pri_q <= '0;
			status_q  <= ST_OK;
			empty_q   <= 1'b1;
			occ_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take) begin
						pay_q     <= payload;
						pri_q     <= priority_req;
						out_pay_q <= '0;
						out_pri_q <= '0;
						status_q  <= ST_OK;
						empty_q   <= (count_q == '0);
						occ_q     <= count_q;
						if (op == OP_DEQ) begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
								done_q   <= 1'b1;
							end else begin
								state_q <= S_DEQ;
							end
						end else if (count_q == CAP_C) begin
							status_q <= ST_FULL;
							done_q   <= 1'b1;
						end else if (count_q == '0) begin
							count_q <= count_inc;
							empty_q <= 1'b0;
							occ_q   <= count_inc;
							done_q  <= 1'b1;
						end else begin
							walk_q  <= count_dec[AW-1:0];
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (rd_lower) begin
						if (walk_q == '0) begin
							state_q <= S_PLACE;
						end else begin
							walk_q <= walk_q - AW'(1);
						end
					end else begin
						count_q <= count_inc;
						empty_q <= 1'b0;
						occ_q   <= count_inc;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_PLACE: begin
					count_q <= count_inc;
					empty_q <= 1'b0;
					occ_q   <= count_inc;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_DEQ: begin
					out_pay_q <= rd_pay;
					out_pri_q <= rd_pri;
					head_q    <= phys(head_q, AW'(1));
					count_q   <= count_dec;
					empty_q   <= (count_dec == '0);
					occ_q     <= count_dec;
					done_q    <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign out_payload  = out_pay_q;
	assign out_priority = out_pri_q;
	assign status       = status_q;
	assign is_empty     = empty_q;
	assign occupancy    = occ_q;

endmodule

[rtl/spq_checker.sv]
`include "stable_priority_queue_defines.svh"

module spq_checker #(
	parameter int CAPACITY      = 16,
	parameter int PAYLOAD_BITS  = 32,
	parameter int PRIORITY_BITS = 4
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [PAYLOAD_BITS-1:0]       out_payload,
	input logic [PRIORITY_BITS-1:0]      out_priority,
	input spq_pkg::status_t              status,
	input logic                          is_empty,
	input logic [$clog2(CAPACITY+1)-1:0] occupancy
);

	import spq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	// An accepted request is either still at work or reports in the next cycle.
	`SPQ_ASSERT_NEXT(a_req_progress, clk, arst_n, start && !busy, busy || done)
	// A result is only shown once the block has gone back to idle.
	`SPQ_ASSERT_IMPLY(a_done_idle, clk, arst_n, done, !busy)
	// The empty flag agrees with the occupancy, which never exceeds the capacity.
	`SPQ_ASSERT_IMPLY(a_occ_flag, clk, arst_n, done, (is_empty == (occupancy == '0)) && (occupancy <= CW'(CAPACITY)))
	// A failed request never hands out an entry.
	`SPQ_ASSERT_IMPLY(a_err_zero, clk, arst_n, done && (status != ST_OK), (out_payload == '0) && (out_priority == '0))

endmodule

bind stable_priority_queue spq_checker #(
	.CAPACITY      (CAPACITY),
	.PAYLOAD_BITS  (PAYLOAD_BITS),
	.PRIORITY_BITS (PRIORITY_BITS)
) u_spq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.out_payload  (out_payload),
	.out_priority (out_priority),
	.status       (status),
	.is_empty     (is_empty),
	.occupancy    (occupancy)
);
